/* rtl/xalu_pkg.sv */
// Shared types, opcodes and helper functions for the x86 integer ALU.
package xalu_pkg;

  // Opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_ADC  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SBB  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_XOR  = 4'd6;
  localparam logic [3:0] OP_SHL  = 4'd7;
  localparam logic [3:0] OP_SHR  = 4'd8;
  localparam logic [3:0] OP_SAR  = 4'd9;
  localparam logic [3:0] OP_MUL  = 4'd10;
  localparam logic [3:0] OP_IMUL = 4'd11;

  // Operand width codes; the unused code behaves as 32 bits
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;

  // Stream payload widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // One ALU request
  typedef struct packed {
    logic [1:0]  wcode;
    logic [31:0] dst;
    logic [31:0] src;
    logic [3:0]  cmd;
  } req_t;

  // Status flags
  typedef struct packed {
    logic of_f;
    logic sf_f;
    logic zf_f;
    logic pf_f;
    logic cf_f;
  } flags_t;

  // Mask of the operand width
  function automatic logic [31:0] width_mask(input logic [1:0] wc);
    logic [31:0] m;
    case (wc)
      WC_8:    m = 32'h0000_00FF;
      WC_16:   m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Top bit of a value at the operand width
  function automatic logic msb_at(input logic [31:0] v, input logic [1:0] wc);
    logic b;
    case (wc)
      WC_8:    b = v[7];
      WC_16:   b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  // Sign-extend a width-masked operand to 32 bits
  function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] wc);
    logic [31:0] r;
    case (wc)
      WC_8:    r = {{24{v[7]}}, v[7:0]};
      WC_16:   r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/xalu_core.sv */
// Combinational datapath: one ALU operation plus the flag update.
module xalu_core import xalu_pkg::*; (
  input  req_t        req,
  input  flags_t      flags_in,
  output logic [63:0] result,
  output flags_t      flags_out
);

  logic [31:0]        m;
  logic [31:0]        a;
  logic [31:0]        b;
  logic [31:0]        a_sx;
  logic [31:0]        b_sx;
  logic [4:0]         cnt;
  logic               cin;
  logic [32:0]        sum;
  logic [33:0]        diff;
  logic [63:0]        shl_wide;
  logic [32:0]        shr_pre;
  logic signed [32:0] sar_in;
  logic signed [32:0] sar_pre;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic [63:0]        p;
  logic               mul_hi;
  logic               imul_ov;
  logic [31:0]        r32;
  logic               set_res;
  logic               signed_mul;

  assign m    = width_mask(req.wcode);
  assign a    = req.dst & m;
  assign b    = req.src & m;
  assign a_sx = sext32(a, req.wcode);
  assign b_sx = sext32(b, req.wcode);
  assign cnt  = req.src[4:0];
  assign cin  = (req.cmd == OP_ADC || req.cmd == OP_SBB) ? flags_in.cf_f : 1'b0;

  // Adder and subtractor; bit 33 of the difference is the true borrow
  assign sum  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
  assign diff = {2'b00, a} - {2'b00, b} - {33'd0, cin};

  // Shifters; in the right shifts the spare low bit catches the last bit shifted out
  assign shl_wide = {32'd0, a} << cnt;
  assign shr_pre  = {a, 1'b0} >> cnt;
  assign sar_in   = {a_sx, 1'b0};
  assign sar_pre  = sar_in >>> cnt;

  // One 33x33 signed multiplier serves mul and imul
  assign signed_mul = (req.cmd == OP_IMUL);
  assign mul_a = signed_mul ? {a_sx[31], a_sx} : {1'b0, a};
  assign mul_b = signed_mul ? {b_sx[31], b_sx} : {1'b0, b};
  assign prod  = mul_a * mul_b;
  assign p     = prod[63:0];

  // Upper-half tests for the product
  always_comb begin
    case (req.wcode)
      WC_8: begin
        mul_hi  = |p[63:8];
        imul_ov = !((&p[63:7]) || !(|p[63:7]));
      end
      WC_16: begin
        mul_hi  = |p[63:16];
        imul_ov = !((&p[63:15]) || !(|p[63:15]));
      end
      default: begin
        mul_hi  = |p[63:32];
        imul_ov = !((&p[63:31]) || !(|p[63:31]));
      end
    endcase
  end

  // Operation select and flag rules
  always_comb begin
    flags_out = flags_in;
    r32       = 32'd0;
    result    = 64'd0;
    set_res   = 1'b0;
    case (req.cmd)
      OP_ADD, OP_ADC: begin
        r32     = sum[31:0] & m;
        set_res = 1'b1;
        case (req.wcode)
          WC_8:    flags_out.cf_f = sum[8];
          WC_16:   flags_out.cf_f = sum[16];
          default: flags_out.cf_f = sum[32];
        endcase
        flags_out.of_f = msb_at((a ^ r32) & (b ^ r32), req.wcode);
      end
      OP_SUB, OP_SBB: begin
        r32            = diff[31:0] & m;
        set_res        = 1'b1;
        flags_out.cf_f = diff[33];
        flags_out.of_f = msb_at((a ^ b) & (a ^ r32), req.wcode);
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (req.cmd == OP_AND) begin
          r32 = a & b;
        end else if (req.cmd == OP_OR) begin
          r32 = a | b;
        end else begin
          r32 = a ^ b;
        end
        set_res        = 1'b1;
        flags_out.cf_f = 1'b0;
        flags_out.of_f = 1'b0;
      end
      OP_SHL: begin
        if (cnt == 5'd0) begin
          r32 = a;
        end else begin
          r32     = shl_wide[31:0] & m;
          set_res = 1'b1;
          case (req.wcode)
            WC_8:    flags_out.cf_f = shl_wide[8];
            WC_16:   flags_out.cf_f = shl_wide[16];
            default: flags_out.cf_f = shl_wide[32];
          endcase
          if (cnt == 5'd1) begin
            flags_out.of_f = msb_at(r32, req.wcode) ^ flags_out.cf_f;
          end
        end
      end
      OP_SHR: begin
        if (cnt == 5'd0) begin
          r32 = a;
        end else begin
          r32            = shr_pre[32:1] & m;
          set_res        = 1'b1;
          flags_out.cf_f = shr_pre[0];
          flags_out.of_f = (cnt == 5'd1) ? msb_at(a, req.wcode) : 1'b0;
        end
      end
      OP_SAR: begin
        if (cnt == 5'd0) begin
          r32 = a;
        end else begin
          r32            = sar_pre[32:1] & m;
          set_res        = 1'b1;
          flags_out.cf_f = sar_pre[0];
          flags_out.of_f = 1'b0;
        end
      end
      OP_MUL: begin
        flags_out.cf_f = mul_hi;
        flags_out.of_f = mul_hi;
      end
      OP_IMUL: begin
        flags_out.cf_f = imul_ov;
        flags_out.of_f = imul_ov;
      end
      default: begin
        r32 = 32'd0;
      end
    endcase

    // Result word: double width for products
    case (req.cmd)
      OP_MUL:  result = p;
      OP_IMUL: begin
        case (req.wcode)
          WC_8:    result = {48'd0, p[15:0]};
          WC_16:   result = {32'd0, p[31:0]};
          default: result = p;
        endcase
      end
      default: result = {32'd0, r32};
    endcase

    // PF, ZF, SF from the masked result
    if (set_res) begin
      flags_out.pf_f = ~^r32[7:0];
      flags_out.zf_f = (r32 == 32'd0);
      flags_out.sf_f = msb_at(r32, req.wcode);
    end
  end

endmodule

/* rtl/x86_integer_alu_with_flags.sv */
// Top level: x86 integer ALU with CF/PF/ZF/SF/OF, input register and result register.
//
//  channel | ports       | tdata fields, lowest bit up
//  --------+-------------+-----------------------------------------------------------
//  request | in_t*       | cmd[3:0] source_operand[35:4] dest_operand[67:36]
//          |             | width_code[69:68], zero pad [71:70]
//  result  | out_t*      | result_value[63:0] carry_out[64] parity_out[65] zero_out[66]
//          |             | sign_out[67] overflow_out[68], zero pad [71:69]
//
// One request per cycle sustained while out_tready is high; an accepted request passes the input
// register and then the result register before out_tvalid rises for it.
// The operation and the flag update are combinational between the input register
// and the result register, so adc/sbb see the carry of the request just ahead.
// Reset clears both valid bits and all five flags.
// A stalled result holds in the result register while the input register keeps the next
// request; in_tready drops only when both are full and out_tready is low.
module x86_integer_alu_with_flags import xalu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd, source_operand, dest_operand, width_code
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // result_value, carry, parity, zero, sign, overflow
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  req_t        s1_req_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_result_r;
  flags_t      flags_r;
  logic [63:0] core_result;
  flags_t      core_flags;
  logic        advance;
  logic        in_take;

  // Stage moves when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  xalu_core u_core (
    .req       (s1_req_r),
    .flags_in  (flags_r),
    .result    (core_result),
    .flags_out (core_flags)
  );

  // Control state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance && s1_valid_r) begin
        flags_r <= core_flags;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_tdata[69:0];
    end
    if (advance && s1_valid_r) begin
      out_result_r <= core_result;
    end
  end

  // Flags load together with the result, so the flag register is the result's flags
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, flags_r.of_f, flags_r.sf_f, flags_r.zf_f,
                       flags_r.pf_f, flags_r.cf_f, out_result_r};

endmodule

/* tb/tb.sv */
// Self-checking testbench for the x86 integer ALU with status flags.
module tb;
  import xalu_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [3:0] OP_RSV_LO = 4'd12;
  localparam logic [3:0] OP_RSV_HI = 4'd15;
  localparam logic [1:0] WC_32     = 2'd2;
  localparam logic [1:0] WC_RSV    = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int          DRAIN_CYCLES = 20;

  // One predicted result: value plus all five flags
  typedef struct packed {
    flags_t      flags;
    logic [63:0] value;
  } alu_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  flags_t      eflags = '0;
  alu_result_t alu_results_due[$];
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          error_count = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int unsigned cycle_count = 0;

  x86_integer_alu_with_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // cmd, source_operand, dest_operand, width_code
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // result_value, carry, parity, zero, sign, overflow
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               alu_results_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Sign-extend a value of width w to 64 bits
  function automatic logic [63:0] sext64(input logic [63:0] v, input int unsigned w);
    logic [63:0] sbit;
    logic [63:0] m;
    sbit = 64'd1 << (w - 1);
    m = (64'd1 << w) - 64'd1;
    return ((v & m) ^ sbit) - sbit;
  endfunction

  // Flag-keeping ALU prediction; updates eflags as the block does
  function automatic alu_result_t compute_alu(input req_t rq);
    int unsigned w;
    logic [63:0] m, a, b, r, s, t, p, sa;
    logic [4:0]  cnt;
    logic [63:0] cin;
    logic        upd;
    logic        ov;
    alu_result_t res;
    w = (rq.wcode == WC_8) ? 8 : (rq.wcode == WC_16) ? 16 : 32;
    m = (64'd1 << w) - 64'd1;
    a = {32'd0, rq.dst} & m;
    b = {32'd0, rq.src} & m;
    cnt = rq.src[4:0];
    cin = {63'd0, eflags.cf_f};
    r = '0;
    upd = 1'b0;
    case (rq.cmd)
      OP_ADD, OP_ADC: begin
        s = a + b + ((rq.cmd == OP_ADC) ? cin : 64'd0);
        r = s & m;
        t = (a ^ r) & (b ^ r);
        eflags.cf_f = s[w];
        eflags.of_f = t[w-1];
        upd = 1'b1;
      end
      OP_SUB, OP_SBB: begin
        s = (rq.cmd == OP_SBB) ? cin : 64'd0;
        r = (a - b - s) & m;
        t = (a ^ b) & (a ^ r);
        eflags.cf_f = (a < b + s);
        eflags.of_f = t[w-1];
        upd = 1'b1;
      end
      OP_AND, OP_OR, OP_XOR: begin
        r = (rq.cmd == OP_AND) ? (a & b) : (rq.cmd == OP_OR) ? (a | b) : (a ^ b);
        eflags.cf_f = 1'b0;
        eflags.of_f = 1'b0;
        upd = 1'b1;
      end
      OP_SHL: begin
        r = a;
        if (cnt != 0) begin
          s = a << cnt;
          r = s & m;
          eflags.cf_f = s[w];
          if (cnt == 1) eflags.of_f = r[w-1] ^ eflags.cf_f;
          upd = 1'b1;
        end
      end
      OP_SHR: begin
        r = a;
        if (cnt != 0) begin
          r = (a >> cnt) & m;
          eflags.cf_f = a[cnt-1];
          eflags.of_f = (cnt == 1) ? a[w-1] : 1'b0;
          upd = 1'b1;
        end
      end
      OP_SAR: begin
        r = a;
        if (cnt != 0) begin
          sa = sext64(a, w);
          // keep the arithmetic shift on its own so it stays signed
          s = $signed(sa) >>> cnt;
          r = s & m;
          eflags.cf_f = sa[cnt-1];
          eflags.of_f = 1'b0;
          upd = 1'b1;
        end
      end
      OP_MUL: begin
        p = a * b;
        r = p;
        eflags.cf_f = ((p >> w) != 0);
        eflags.of_f = eflags.cf_f;
      end
      OP_IMUL: begin
        p = sext64(a, w) * sext64(b, w);
        ov = (sext64(p, w) != p);
        r = (w == 32) ? p : (p & ((64'd1 << (2 * w)) - 64'd1));
        eflags.cf_f = ov;
        eflags.of_f = ov;
      end
      default: r = '0;  // reserved opcode: flags untouched
    endcase
    // Result-derived flags for ops that set them
    if (upd) begin
      eflags.pf_f = ~^r[7:0];
      eflags.zf_f = (r == 64'd0);
      eflags.sf_f = r[w-1];
    end
    res.value = r;
    res.flags = eflags;
    return res;
  endfunction

  // Drive one request, wait for acceptance, record its prediction
  task automatic send_request(input logic [3:0] op, input logic [31:0] src,
                              input logic [31:0] dst, input logic [1:0] wc);
    req_t rq;
    rq.cmd = op;
    rq.src = src;
    rq.dst = dst;
    rq.wcode = wc;
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(req_t)){1'b0}}, rq};
    do @(posedge clk); while (!in_tready);
    alu_results_due.push_back(compute_alu(rq));
    requests_sent++;
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", fname, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    alu_result_t want;
    flags_t      got;
    if (alu_results_due.size() == 0) begin
      $error("result %h arrived with no request outstanding", data);
      error_count++;
    end else begin
      want = alu_results_due.pop_front();
      got = flags_t'(data[68:64]);
      compare_field("result_value", want.value, data[63:0]);
      compare_field("carry_out", 64'(want.flags.cf_f), 64'(got.cf_f));
      compare_field("parity_out", 64'(want.flags.pf_f), 64'(got.pf_f));
      compare_field("zero_out", 64'(want.flags.zf_f), 64'(got.zf_f));
      compare_field("sign_out", 64'(want.flags.sf_f), 64'(got.sf_f));
      compare_field("overflow_out", 64'(want.flags.of_f), 64'(got.of_f));
      results_checked++;
    end
  endtask

  // Result side: random backpressure and checking of each accepted result
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= out_stall_pct);
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Carry chains, borrow and signed overflow at every width
  task automatic test_add_sub_carry();
    send_request(OP_ADD, 32'h0000_0001, 32'h0000_00FF, WC_8);
    send_request(OP_ADC, 32'h0000_0000, 32'h0000_007F, WC_8);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WC_32);
    send_request(OP_SUB, 32'h0000_0001, 32'h0000_0000, WC_16);
    send_request(OP_SBB, 32'h0000_0000, 32'h0000_8000, WC_16);
    send_request(OP_SBB, 32'hFFFF_FFFF, 32'h0000_0000, WC_32);
  endtask

  // Logic ops clear CF and OF
  task automatic test_logic_ops();
    send_request(OP_AND, 32'h0000_0000, 32'hFFFF_FFFF, WC_32);
    send_request(OP_OR,  32'hFFFF_FF80, 32'h1234_5601, WC_8);
    send_request(OP_XOR, 32'hA5A5_FFFF, 32'h5A5A_7FFF, WC_16);
  endtask

  // Count of one, zero count keeping flags, counts past the width, count modulo 32
  task automatic test_shifts();
    send_request(OP_SHL, 32'h0000_0001, 32'h0000_00C0, WC_8);
    send_request(OP_SHL, 32'h0000_0000, 32'h0000_0055, WC_8);
    send_request(OP_SHL, 32'h0000_0014, 32'h0000_FFFF, WC_16);
    send_request(OP_SHR, 32'h0000_0001, 32'h8000_0001, WC_32);
    send_request(OP_SHR, 32'h0000_001F, 32'h0000_00FF, WC_8);
    send_request(OP_SAR, 32'h0000_0001, 32'h0000_0081, WC_8);
    send_request(OP_SAR, 32'h0000_001F, 32'h0000_8000, WC_16);
    send_request(OP_SHL, 32'h0000_0021, 32'hC000_0000, WC_32);
  endtask

  // Double-width products, unsigned and signed overflow
  task automatic test_multiply();
    send_request(OP_MUL,  32'h0000_00FF, 32'h0000_00FF, WC_8);
    send_request(OP_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, WC_32);
    send_request(OP_IMUL, 32'h0000_0080, 32'h0000_0080, WC_8);
    send_request(OP_IMUL, 32'h0000_FFFF, 32'h0000_FFFF, WC_16);
    send_request(OP_IMUL, 32'hFFFF_FFFF, 32'h8000_0000, WC_32);
  endtask

  // Unused opcodes and the unused width code
  task automatic test_reserved_codes();
    send_request(OP_RSV_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WC_RSV);
    send_request(OP_RSV_HI, 32'h1234_5678, 32'h9ABC_DEF0, WC_8);
    send_request(OP_ADD,    32'h8000_0000, 32'h8000_0000, WC_RSV);
  endtask

  task automatic run_traffic_phase(input int n, input int in_pct, input int out_pct);
    logic [3:0]  op;
    logic [31:0] src;
    logic [31:0] dst;
    logic [1:0]  wc;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    repeat (n) begin
      op = ($urandom_range(9) == 0) ? 4'($urandom_range(OP_RSV_HI, OP_RSV_LO))
                                    : 4'($urandom_range(OP_IMUL, OP_ADD));
      wc = 2'($urandom_range(3));
      dst = rand_operand();
      src = rand_operand();
      // lean toward counts of zero and one for shifts
      if (op == OP_SHL || op == OP_SHR || op == OP_SAR)
        src[4:0] = ($urandom_range(3) == 0) ? 5'($urandom_range(1)) : 5'($urandom_range(31));
      send_request(op, src, dst, wc);
    end
    wait_results_drained();
  endtask

  // Random traffic under each idling pattern, draining between phases
  task automatic test_random_traffic();
    run_traffic_phase(125, 0, 0);
    run_traffic_phase(125, 85, 0);
    run_traffic_phase(125, 0, 85);
    run_traffic_phase(125, 7, 7);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_add_sub_carry();
    test_logic_ops();
    test_shifts();
    test_multiply();
    test_reserved_codes();
    wait_results_drained();
    test_random_traffic();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (directed flag cases, then random ops at all widths",
             requests_sent);
    $display("under four idle/stall patterns); checked %0d results, %0d errors",
             results_checked, error_count);
    if (error_count == 0 && alu_results_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/xalu_pkg.sv
rtl/xalu_core.sv
rtl/x86_integer_alu_with_flags.sv
tb/tb.sv
